### hdl/tdpt_pkg.sv
// Package for the trial division prime test.
// Holds the default number width, the trial sequence constants and the divider status type.
// No dependencies.
package tdpt_pkg;

	localparam int NUMBER_WIDTH_DEF = 32;

	localparam int FIRST_DIVISOR    = 5;
	localparam int DIVISOR_STRIDE   = 6;
	localparam int SUITABLE_MODULUS = 4;
	localparam int STEP_DIVISOR     = 2;
	localparam int FACTOR_THREE     = 3;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

### hdl/tdpt_serial_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, WIDTH quotient bits per division.
// Depends on tdpt_pkg (status type and default width).
module tdpt_serial_div #(
	parameter int WIDTH = tdpt_pkg::NUMBER_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [WIDTH-1:0]      dividend,
	input  logic [WIDTH-1:0]      divisor,
	output logic [WIDTH-1:0]      quotient,
	output logic [WIDTH-1:0]      remainder,
	output tdpt_pkg::div_stat_t   stat
);

	localparam int CW = $clog2(WIDTH);

	logic [WIDTH-1:0] a_q;
	logic [WIDTH-1:0] d_q;
	logic [WIDTH-1:0] r_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [WIDTH:0]   trial;
	logic [WIDTH:0]   diff;

	// Shift the next dividend bit into the partial remainder, try the subtract.
	assign trial = {r_q, a_q[WIDTH-1]};
	assign diff  = trial - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(WIDTH - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= dividend;
			d_q <= divisor;
			r_q <= '0;
		end else if (busy_q) begin
			a_q <= {a_q[WIDTH-2:0], ~diff[WIDTH]};
			// Restore on a negative difference.
			r_q <= diff[WIDTH] ? trial[WIDTH-1:0] : diff[WIDTH-1:0];
		end
	end

	assign quotient  = a_q;
	assign remainder = r_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

### hdl/trial_division_prime_test.sv
// Top level of the trial division prime test: control sequencer and output register.
// Depends on tdpt_pkg and tdpt_serial_div.
//
// Usage:
//   Slave channel s_*: one item per candidate, s_tdata holds the two's complement
//   candidate in the low NUMBER_WIDTH bits. Master channel m_*: one item per
//   candidate, m_tdata bit 0 = prime, bit 1 = suitable (prime and n mod 4 == 1).
//   Results come out in input order, one per candidate.
//   Negative numbers, 0, 1, 2, 3 and even numbers are settled by the screen alone.
//   Others run one bit-serial division by 3, then divisions by i and i+2 for
//   i = 5, 11, 17, ... while i <= n / i. Each division runs on the single
//   shared serial divider. One item is in work at a time. The loop bound
//   uses the quotient of the same division, so no squaring. The finished
//   result sits in an output register; the next candidate is taken while it
//   waits. When the receiver stalls with the register full, the block holds
//   the next result until the register frees.
//   Reset (arst_n low, asynchronous) drops any item in work and clears m_tvalid.
module trial_division_prime_test #(
	parameter int NUMBER_WIDTH = tdpt_pkg::NUMBER_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// fields from bit 0: candidate
	input  logic [((NUMBER_WIDTH+7)/8)*8-1:0]   s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// fields from bit 0: prime, suitable
	output logic [7:0]                          m_tdata
);

	localparam int W = NUMBER_WIDTH;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_DIV3  = 5'b00010,
		ST_DIVI  = 5'b00100,
		ST_DIVI2 = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	state_t               state_q;
	state_t               state_d;
	logic [W-1:0]         n_q;
	logic [W-1:0]         i_q;
	logic [W-1:0]         i_d;
	logic                 res_q;
	logic                 res_d;
	logic                 m_valid_q;
	logic                 prime_q;
	logic                 suitable_q;
	logic                 accept;
	logic                 div_start;
	logic [W-1:0]         div_dividend;
	logic [W-1:0]         div_divisor;
	logic [W-1:0]         div_quot;
	logic [W-1:0]         div_rem;
	tdpt_pkg::div_stat_t  div_stat;
	logic [W-1:0]         n_in;
	logic                 load_out;

	assign n_in     = s_tdata[W-1:0];
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign load_out = (state_q == ST_EMIT) && (!m_valid_q || m_tready);

	// Sequencer: screen negative, small and even numbers, then walk the trial divisors.
	always_comb begin
		state_d      = state_q;
		i_d          = i_q;
		res_d        = res_q;
		div_start    = 1'b0;
		div_dividend = n_q;
		div_divisor  = i_q;
		unique case (state_q)
			ST_IDLE: begin
				div_dividend = n_in;
				div_divisor  = W'(tdpt_pkg::FACTOR_THREE);
				if (accept) begin
					if (n_in[W-1] || n_in <= W'(1)) begin
						res_d   = 1'b0;
						state_d = ST_EMIT;
					end else if (n_in == W'(2) || n_in == W'(tdpt_pkg::FACTOR_THREE)) begin
						res_d   = 1'b1;
						state_d = ST_EMIT;
					end else if (!n_in[0]) begin
						res_d   = 1'b0;
						state_d = ST_EMIT;
					end else begin
						div_start = 1'b1;
						state_d   = ST_DIV3;
					end
				end
			end
			ST_DIV3: begin
				div_divisor = W'(tdpt_pkg::FIRST_DIVISOR);
				if (div_stat.done) begin
					if (div_rem == '0) begin
						res_d   = 1'b0;
						state_d = ST_EMIT;
					end else begin
						i_d       = W'(tdpt_pkg::FIRST_DIVISOR);
						div_start = 1'b1;
						state_d   = ST_DIVI;
					end
				end
			end
			ST_DIVI: begin
				div_divisor = i_q + W'(tdpt_pkg::STEP_DIVISOR);
				if (div_stat.done) begin
					if (div_quot < i_q) begin
						// i squared exceeds n: no factor left to try.
						res_d   = 1'b1;
						state_d = ST_EMIT;
					end else if (div_rem == '0) begin
						res_d   = 1'b0;
						state_d = ST_EMIT;
					end else begin
						div_start = 1'b1;
						state_d   = ST_DIVI2;
					end
				end
			end
			ST_DIVI2: begin
				div_divisor = i_q + W'(tdpt_pkg::DIVISOR_STRIDE);
				if (div_stat.done) begin
					if (div_rem == '0) begin
						res_d   = 1'b0;
						state_d = ST_EMIT;
					end else begin
						i_d       = i_q + W'(tdpt_pkg::DIVISOR_STRIDE);
						div_start = 1'b1;
						state_d   = ST_DIVI;
					end
				end
			end
			ST_EMIT: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		i_q   <= i_d;
		res_q <= res_d;
		if (accept) begin
			n_q <= n_in;
		end
		if (load_out) begin
			prime_q    <= res_q;
			suitable_q <= res_q && (n_q[1:0] == 2'b01);
		end
	end

	tdpt_serial_div #(
		.WIDTH(W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.quotient  (div_quot),
		.remainder (div_rem),
		.stat      (div_stat)
	);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'b000000, suitable_q, prime_q};

endmodule

### test/trial_division_prime_test_tb.sv
// Self-checking testbench for trial_division_prime_test: directed table plus random candidates.
// Compares each result against a hand-typed verdict or an in-bench primality predictor, with random handshake idling.
// Depends on tdpt_pkg and the trial_division_prime_test RTL.
module trial_division_prime_test_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NW             = tdpt_pkg::NUMBER_WIDTH_DEF;
	localparam int SW             = ((NW + 7) / 8) * 8;
	// slowest correct gap is one full-range prime
	localparam int WATCHDOG_LIMIT = 2000000;
	localparam int HOLD_CYCLES    = 20000;
	localparam int DRAIN_CYCLES   = 50;
	localparam int N_DIRECTED     = 23;
	localparam int N_RANDOM_PHASE = 26;

	// verdict on one candidate, prime in the upper bit
	typedef struct packed {
		logic prime;
		logic suitable;
	} verdict_t;

	// one row of the directed table; fixed marks a verdict typed in by hand
	typedef struct packed {
		logic [NW-1:0] cand;
		logic          fixed;
		verdict_t      verdict;
	} cand_row_t;

	localparam cand_row_t DIRECTED [N_DIRECTED] = '{
		'{32'd0,          1'b1, 2'b00},
		'{32'd1,          1'b1, 2'b00},
		'{32'd2,          1'b1, 2'b10},
		'{32'd3,          1'b1, 2'b10},
		'{32'd4,          1'b1, 2'b00},
		'{32'd5,          1'b1, 2'b11},
		'{32'd7,          1'b1, 2'b10},
		'{32'd9,          1'b1, 2'b00},
		'{32'd13,         1'b1, 2'b11},
		'{32'd25,         1'b1, 2'b00},
		'{32'd49,         1'b0, 2'b00},
		'{32'd97,         1'b0, 2'b00},
		'{32'd121,        1'b0, 2'b00},
		'{32'd323,        1'b0, 2'b00},
		'{32'd65521,      1'b0, 2'b00},
		'{32'd65537,      1'b0, 2'b00},
		'{32'd1000003,    1'b0, 2'b00},
		'{32'hFFFF_FFFF,  1'b1, 2'b00},
		'{32'h8000_0000,  1'b1, 2'b00},
		'{32'hAAAA_AAAA,  1'b1, 2'b00},
		'{32'h5555_5555,  1'b0, 2'b00},
		'{32'h7FFF_FFFE,  1'b1, 2'b00},
		'{32'h7FFF_FFFF,  1'b0, 2'b00}
	};

	logic          clk;
	logic          arst_n;
	logic          s_tvalid;
	logic          s_tready;
	// fields from bit 0: candidate
	logic [SW-1:0] s_tdata;
	logic          m_tvalid;
	logic          m_tready;
	// fields from bit 0: prime, suitable
	logic [7:0]    m_tdata;

	// sideband that travels with the offered item, driven like the bus itself
	logic          row_fixed;
	verdict_t      row_verdict;

	verdict_t      pending_verdicts[$];
	int            mismatches;
	int            items_in;
	int            results_out;
	int            primes_seen;
	int            suitable_seen;
	int            stall_cycles;
	int            send_idle;
	int            recv_idle;
	int            phase;
	bit            hold_done;

	trial_division_prime_test #(
		.NUMBER_WIDTH(NW)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Predict the verdict: sign bit set, 0 and 1 are not prime, 2 and 3 are,
	// other multiples of 2 or 3 are not, then try i and i+2 for i = 5, 11, ...
	// while i <= n / i, which keeps the bound free of overflow at the top.
	function automatic verdict_t classify_candidate(input logic [NW-1:0] cand);
		logic [63:0] n;
		logic [63:0] i;
		logic        found_prime;
		verdict_t    v;
		n = 64'(cand);
		if (cand[NW-1]) begin
			found_prime = 1'b0;
		end else if (n <= 64'd1) begin
			found_prime = 1'b0;
		end else if (n == 64'd2 || n == 64'd3) begin
			found_prime = 1'b1;
		end else if ((n % 64'd2) == 0 || (n % 64'(tdpt_pkg::FACTOR_THREE)) == 0) begin
			found_prime = 1'b0;
		end else begin
			found_prime = 1'b1;
			for (i = 64'(tdpt_pkg::FIRST_DIVISOR); found_prime && i <= n / i;
					i += 64'(tdpt_pkg::DIVISOR_STRIDE)) begin
				if ((n % i) == 0 || (n % (i + 64'd2)) == 0)
					found_prime = 1'b0;
			end
		end
		v.prime    = found_prime;
		v.suitable = found_prime && ((n % 64'(tdpt_pkg::SUITABLE_MODULUS)) == 64'd1);
		return v;
	endfunction

	// Draw a candidate. Most are odd and mid-sized so that the trial loop runs
	// for a while; full-range positives are kept even or multiples of five so
	// that none of them costs a full-range prime's worth of cycles.
	function automatic logic [NW-1:0] draw_candidate();
		int unsigned   sel;
		logic [NW-1:0] c;
		sel = $urandom_range(99);
		if (sel < 45) begin
			c = NW'($urandom_range(4095, 5)) | NW'(1);
		end else if (sel < 65) begin
			c = NW'($urandom_range(65535, 4096)) | NW'(1);
		end else if (sel < 73) begin
			c = NW'($urandom_range(1 << 20, 65536)) | NW'(1);
		end else if (sel < 85) begin
			c = NW'($urandom()) | (NW'(1) << (NW - 1));
		end else if (sel < 91) begin
			c = NW'($urandom()) & ~(NW'(1) << (NW - 1)) & ~NW'(1);
		end else if (sel < 96) begin
			c = NW'(($urandom() & 32'h0FFF_FFFF) * 5);
		end else begin
			c = NW'($urandom_range(16));
		end
		return c;
	endfunction

	task automatic report_mismatch(input string what);
		$display("MISMATCH @%0t: %s", $realtime, what);
		mismatches++;
	endtask

	// Offer one item; idle first at the current sender rate, then hold valid
	// until the block takes it.
	task automatic offer_candidate(input logic [NW-1:0] cand, input logic fixed,
			input verdict_t v);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid    <= 1'b1;
		s_tdata     <= SW'(cand);
		row_fixed   <= fixed;
		row_verdict <= v;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Receiver: ready at random per phase, with one long hold-off at the start of
	// the last phase so that the output register fills and the input stalls.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (phase == 2 && !hold_done) begin
				hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1)
					@(posedge clk);
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	// Monitor: values here are the ones before the edge, so the order of events
	// in the time step does not matter. Record the expected verdict on input
	// acceptance and compare on output acceptance.
	always @(posedge clk) begin
		verdict_t want;
		verdict_t got;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				items_in++;
				if (row_fixed)
					pending_verdicts.insert(pending_verdicts.size(), row_verdict);
				else
					pending_verdicts.insert(pending_verdicts.size(),
						classify_candidate(s_tdata[NW-1:0]));
			end
			if (m_tvalid && m_tready) begin
				results_out++;
				got.prime    = m_tdata[0];
				got.suitable = m_tdata[1];
				primes_seen   += got.prime;
				suitable_seen += got.suitable;
				if (pending_verdicts.size() == 0) begin
					report_mismatch("result with no pending candidate");
				end else begin
					want = pending_verdicts.pop_front();
					if (got.prime !== want.prime)
						report_mismatch($sformatf("result %0d prime got %b want %b",
							results_out, got.prime, want.prime));
					if (got.suitable !== want.suitable)
						report_mismatch($sformatf("result %0d suitable got %b want %b",
							results_out, got.suitable, want.suitable));
				end
			end
			// watchdog: count cycles with no item moving on either side
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no item moved for %0d cycles", stall_cycles);
				$display("trial_division_prime_test verification failed");
				$finish;
			end
		end
	end

	initial begin
		// drive every input to a known value and hold reset
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		row_fixed     = 1'b0;
		row_verdict   = '0;
		mismatches    = 0;
		items_in      = 0;
		results_out   = 0;
		primes_seen   = 0;
		suitable_seen = 0;
		stall_cycles  = 0;
		hold_done     = 1'b0;
		phase         = 0;
		send_idle     = 33;
		recv_idle     = 80;
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// phase 0: directed table, then random, sender idling lightly
		for (int r = 0; r < N_DIRECTED; r++)
			offer_candidate(DIRECTED[r].cand, DIRECTED[r].fixed, DIRECTED[r].verdict);
		for (int k = 0; k < N_RANDOM_PHASE; k++)
			offer_candidate(draw_candidate(), 1'b0, '0);

		// phase 1: swap the idle rates
		phase     = 1;
		send_idle = 80;
		recv_idle = 33;
		for (int k = 0; k < N_RANDOM_PHASE; k++)
			offer_candidate(draw_candidate(), 1'b0, '0);

		// phase 2: no idling, but the receiver holds off once at the start
		phase     = 2;
		send_idle = 0;
		recv_idle = 0;
		for (int k = 0; k < N_RANDOM_PHASE; k++)
			offer_candidate(draw_candidate(), 1'b0, '0);
		s_tvalid <= 1'b0;

		// drain: the watchdog ends the run if a result never shows up
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		$display("Ran %0d candidates (directed table, small, mid and full-range values,",
			items_in);
		$display("negatives) over three idle mixes; %0d results, %0d prime, %0d suitable.",
			results_out, primes_seen, suitable_seen);
		if (mismatches == 0) begin
			$display("trial_division_prime_test verification clean");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("trial_division_prime_test verification failed");
		end
		$finish;
	end

endmodule
